### src/sku_pkg.sv
// Shared types and constants for the secret key unpacker.
`default_nettype none
package sku_pkg;

	// section codes
	localparam logic [2:0] SEC_RHO  = 3'd0;
	localparam logic [2:0] SEC_KEY  = 3'd1;
	localparam logic [2:0] SEC_TR   = 3'd2;
	localparam logic [2:0] SEC_S1   = 3'd3;
	localparam logic [2:0] SEC_S2   = 3'd4;
	localparam logic [2:0] SEC_T0   = 3'd5;
	localparam logic [2:0] SEC_DONE = 3'd6;

	localparam int BUF_W       = 20;
	localparam int HELD_W      = 5;
	localparam int VAL_W       = 14;
	localparam int SHORT_BITS  = 3;
	localparam int LONG_BITS   = 13;
	localparam int MAX_FIELDS  = 3;
	localparam logic [VAL_W-1:0] ETA_OFFSET  = 14'd2;
	localparam logic [VAL_W-1:0] LONG_OFFSET = 14'd4096;
	localparam logic [7:0] COEFF_LAST = 8'd255;

	typedef struct packed {
		logic [2:0]       section;
		logic [2:0]       poly;
		logic [7:0]       elem;
		logic [VAL_W-1:0] value;
		logic             done;
	} rec_t;

	typedef struct packed {
		logic [1:0] count;
		rec_t [MAX_FIELDS-1:0] rec;
	} run_t;

endpackage
`default_nettype wire

### src/sku_front.sv
// Front end: takes key bytes, tracks position and bit buffer, builds result runs.
`default_nettype none
module sku_front #(
	parameter int SEED_BYTES   = 32,
	parameter int SECRET_POLYS = 7,
	parameter int ROW_POLYS    = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  key_byte,
	input  wire logic        restart,
	input  wire logic        q_full,
	output logic             push,
	output sku_pkg::run_t    push_run
);
	import sku_pkg::*;

	logic [2:0]        sec_q, sec_e;
	logic [2:0]        poly_q, poly_e;
	logic [7:0]        elem_q, elem_e;
	logic [BUF_W-1:0]  buf_q, buf_e, buf_all;
	logic [HELD_W-1:0] held_q, held_e, tot;
	logic              is_seed, is_coef, is_long, stop, bnd, last_poly;
	logic [1:0]        n;
	logic [HELD_W-1:0] used;
	logic [12:0]       f;
	logic [7:0]        e_k;
	logic [2:0]        poly_max;

	assign in_ready = !q_full;

	always_comb begin
		sec_e  = restart ? SEC_RHO : sec_q;
		poly_e = restart ? 3'd0 : poly_q;
		elem_e = restart ? 8'd0 : elem_q;
		buf_e  = restart ? '0 : buf_q;
		held_e = restart ? '0 : held_q;

		is_seed  = (sec_e < SEC_S1);
		is_coef  = !is_seed && (sec_e < SEC_DONE);
		is_long  = (sec_e == SEC_T0);
		buf_all  = buf_e | (BUF_W'(key_byte) << held_e);
		tot      = held_e + 5'd8;
		poly_max = (sec_e == SEC_S1) ? 3'(SECRET_POLYS - 1) : 3'(ROW_POLYS - 1);
		last_poly = (poly_e == poly_max);

		n    = 2'd0;
		stop = 1'b0;
		bnd  = 1'b0;
		f    = '0;
		e_k  = '0;
		push_run = '0;

		if (is_seed) begin
			push_run.count = 2'd1;
			push_run.rec[0].section = sec_e;
			push_run.rec[0].poly    = 3'd0;
			push_run.rec[0].elem    = elem_e;
			push_run.rec[0].value   = VAL_W'(key_byte);
			push_run.rec[0].done    = 1'b0;
		end else begin
			// up to three short fields or one long field per byte;
			// a polynomial boundary ends the run
			for (int k = 0; k < MAX_FIELDS; k++) begin
				if (!stop && (is_long ? (k == 0 && tot >= HELD_W'(LONG_BITS))
						: (tot >= HELD_W'(SHORT_BITS * (k + 1))))) begin
					f   = is_long ? buf_all[LONG_BITS-1:0]
						: 13'(buf_all[SHORT_BITS*k +: SHORT_BITS]);
					e_k = elem_e + 8'(k);
					push_run.rec[k].section = sec_e;
					push_run.rec[k].poly    = poly_e;
					push_run.rec[k].elem    = e_k;
					push_run.rec[k].value   = is_long ? (LONG_OFFSET - VAL_W'(f))
						: (ETA_OFFSET - VAL_W'(f));
					push_run.rec[k].done    = (e_k == COEFF_LAST) && last_poly && is_long;
					if (e_k == COEFF_LAST) begin
						bnd  = 1'b1;
						stop = 1'b1;
					end
					n = n + 2'd1;
				end else begin
					stop = 1'b1;
				end
			end
			push_run.count = n;
		end

		used = is_long ? ((n != 2'd0) ? HELD_W'(LONG_BITS) : '0)
			: HELD_W'(n) * HELD_W'(SHORT_BITS);

		push = in_valid && in_ready && (is_seed || (is_coef && n != 2'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_RHO;
			poly_q <= '0;
			elem_q <= '0;
			buf_q  <= '0;
			held_q <= '0;
		end else if (in_valid && in_ready) begin
			sec_q  <= sec_e;
			poly_q <= poly_e;
			elem_q <= elem_e;
			buf_q  <= buf_e;
			held_q <= held_e;
			if (is_seed) begin
				if (elem_e == 8'(SEED_BYTES - 1)) begin
					elem_q <= '0;
					sec_q  <= sec_e + 3'd1;
				end else begin
					elem_q <= elem_e + 8'd1;
				end
			end else if (is_coef) begin
				if (bnd) begin
					elem_q <= '0;
					buf_q  <= '0;
					held_q <= '0;
					if (last_poly) begin
						poly_q <= '0;
						sec_q  <= sec_e + 3'd1;
					end else begin
						poly_q <= poly_e + 3'd1;
					end
				end else begin
					elem_q <= elem_e + 8'(n);
					buf_q  <= buf_all >> used;
					held_q <= tot - used;
				end
			end
		end
	end

endmodule
`default_nettype wire

### src/sku_queue.sv
// Two-entry queue of result runs between front and back.
`default_nettype none
module sku_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sku_pkg::run_t push_run,
	input  wire logic          pop,
	output sku_pkg::run_t      head,
	output logic               full,
	output logic               empty
);
	import sku_pkg::*;

	run_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/sku_back.sv
// Back end: walks the head run one result per cycle, while the output is not stalled, into the output register.
`default_nettype none
module sku_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sku_pkg::run_t head,
	input  wire logic          empty,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        out_data,
	output logic               out_last,
	output logic               out_done
);
	import sku_pkg::*;

	logic [1:0] slot_q;
	logic       valid_q;
	rec_t       rec_q;
	logic       last_q;
	rec_t       cur;
	logic       load, cur_last;

	assign cur      = head.rec[slot_q];
	assign cur_last = (slot_q == head.count - 2'd1);
	assign load     = !empty && (!valid_q || out_ready);
	assign pop      = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				slot_q  <= cur_last ? 2'd0 : slot_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q  <= cur;
			last_q <= cur_last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {4'd0, rec_q.value, rec_q.elem, rec_q.poly, rec_q.section};
	assign out_last  = last_q;
	assign out_done  = rec_q.done;

endmodule
`default_nettype wire

### src/secret_key_unpacker_top.sv
// Path: an accepted byte's run is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle on input while the queue is not full; the output register
// gives one result per cycle while not stalled, so a byte yields up to three results (seed
// bytes one, t0 bytes none or one, s1/s2 bytes two or three); the two-run queue covers short
// bursts, and over s1/s2 three bytes give eight results, so the output side paces the input.
// Reset: arst_n clears position, bit buffer, queue and output valid at once.
`default_nettype none
module secret_key_unpacker_top #(
	parameter int SEED_BYTES   = 32,
	parameter int SECRET_POLYS = 7,
	parameter int ROW_POLYS    = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input request: one key byte
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
	input  wire logic        s_tuser,   // [0] restart
	// output request: one result
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [2:0] section, [5:3] poly_index,
	                                    // [13:6] element_index, [27:14] value, rest 0
	output logic             m_tlast,   // last_of_run
	output logic             m_tuser    // [0] key_done
);
	import sku_pkg::*;

	logic push, pop, q_full, q_empty;
	run_t push_run, head;

	// front classifies the byte and builds the whole run for it
	sku_front #(
		.SEED_BYTES  (SEED_BYTES),
		.SECRET_POLYS(SECRET_POLYS),
		.ROW_POLYS   (ROW_POLYS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.key_byte(s_tdata),
		.restart (s_tuser),
		.q_full  (q_full),
		.push    (push),
		.push_run(push_run)
	);

	// short queue so the byte side keeps moving while results drain
	sku_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_run(push_run),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back serialises each run, one result per cycle while the output is not stalled
	sku_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast),
		.out_done (m_tuser)
	);

endmodule
`default_nettype wire

### src/sku_checker.sv
// Port-level checks for the secret key unpacker, bound to the top level.
`default_nettype none
module sku_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);
	import sku_pkg::*;

	// stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// end of key always closes a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("key_done without last_of_run");

	// end of key only on the final t0 coefficient
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[2:0] == SEC_T0) && (m_tdata[13:6] == COEFF_LAST))
		else $error("key_done at wrong position");

	// seed bytes come one result per byte
	a_seed_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == SEC_RHO || m_tdata[2:0] == SEC_KEY
			|| m_tdata[2:0] == SEC_TR) |-> m_tlast)
		else $error("seed result not last of run");

endmodule

bind secret_key_unpacker_top sku_checker u_sku_checker (.*);
`default_nettype wire
